[design/pst_pkg.sv]
package pst_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned USED_W  = 9;
  localparam int unsigned EVICT_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_WRITE  = 2'd2
  } pst_mode_e;

  typedef struct packed {
    logic lookup;
    logic commit;
    logic write;
    logic touch;
    logic hit;
    logic full;
  } pst_ctrl_t;

endpackage

[design/pst_cell.sv]
module pst_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned TAG_BITS    = 20,
  parameter int unsigned SIG_BITS    = 12,
  parameter int unsigned OFFSET_BITS = 6,
  parameter int unsigned AGE_W       = 8,
  parameter int unsigned CNT_W       = 9
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pst_pkg::pst_ctrl_t                      ctrl_i,
  input  logic [TAG_BITS-1:0]                     tag_i,
  input  logic [SIG_BITS-1:0]                     sig_i,
  input  logic [OFFSET_BITS-1:0]                  off_i,
  input  logic [AGE_W-1:0]                        age_i,
  input  logic [CNT_W-1:0]                        cnt_i,
  output logic [SIG_BITS+OFFSET_BITS+AGE_W:0]     rd_o
);
  import pst_pkg::*;

  logic                   valid_q;
  logic [AGE_W-1:0]       age_q;
  logic                   match_q;
  logic                   sel_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic [SIG_BITS-1:0]    sig_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic                   tgt;
  logic                   wr_en;

  assign tgt   = match_q || (!ctrl_i.hit && sel_q);
  assign wr_en = ctrl_i.commit && ctrl_i.write && tgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= AGE_W'(ENTRIES - 1);
      match_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (ctrl_i.lookup) begin
        match_q <= valid_q && (tag_q == tag_i);
        sel_q   <= ctrl_i.full ? (age_q == AGE_W'(ENTRIES - 1)) : (cnt_i == CNT_W'(IDX));
      end
      if (wr_en) begin
        valid_q <= 1'b1;
      end
      if (ctrl_i.commit && ctrl_i.touch) begin
        if (tgt) begin
          age_q <= '0;
        end else if (age_q < age_i) begin
          age_q <= age_q + AGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_q <= tag_i;
      sig_q <= sig_i;
      off_q <= off_i;
    end
  end

  assign rd_o = match_q ? {1'b1, sig_q, off_q, age_q} : '0;

endmodule

[design/pst_tree.sv]
module pst_tree #(
  parameter int unsigned N = 256,
  parameter int unsigned W = 27
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);
  import pst_pkg::*;

  function automatic int unsigned lvl_base(int unsigned pad, int unsigned lvl);
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < lvl; i++) begin
      acc += pad >> (2 * (i + 1));
    end
    return acc;
  endfunction

  localparam int unsigned LEVELS = ($clog2(N) + 1) / 2;
  localparam int unsigned PAD    = 1 << (2 * LEVELS);
  localparam int unsigned NODES  = (PAD - 1) / 3;

  logic [W-1:0] node_q [NODES];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int unsigned NOUT = PAD >> (2 * (l + 1));
    localparam int unsigned BASE = lvl_base(PAD, l);
    for (genvar k = 0; k < NOUT; k++) begin : g_node
      logic [W-1:0] kid [4];
      for (genvar j = 0; j < 4; j++) begin : g_kid
        if (l == 0) begin : g_leaf
          if (4 * k + j < N) begin : g_real
            assign kid[j] = leaf_i[4*k+j];
          end else begin : g_pad
            assign kid[j] = '0;
          end
        end else begin : g_inner
          localparam int unsigned IBASE = BASE - (PAD >> (2 * l));
          assign kid[j] = node_q[IBASE+4*k+j];
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[BASE+k] <= kid[0] | kid[1] | kid[2] | kid[3];
      end
    end
  end

  assign root_o = node_q[NODES-1];

endmodule

[design/prefetch_signature_table_unit.sv]
// an input is captured in S_IDLE; in S_LOOK the cells register their tag match, in S_TREE the
// registered 4-ary or-tree of LEVELS = ceil(log4(ENTRIES)) levels gathers the matching cell,
// and S_COMMIT updates the table and the output register; one item in flight at a time, and
// a new item is taken while the previous result still waits in the output register
// reset (rst_ni low, asynchronous) empties the table, sets all ages to ENTRIES-1
// and clears the entry and eviction counters; no clearing pass is needed
module prefetch_signature_table_unit #(
  parameter int unsigned ENTRIES     = 256,
  parameter int unsigned TAG_BITS    = 20,
  parameter int unsigned SIG_BITS    = 12,
  parameter int unsigned DELTA_BITS  = 7,
  parameter int unsigned OFFSET_BITS = 6,
  parameter int unsigned SIG_SHIFT   = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pst_pkg::MODE_W-1:0]   mode_i,
  input  logic [TAG_BITS-1:0]          page_tag_i,
  input  logic [OFFSET_BITS-1:0]       block_offset_i,
  input  logic [SIG_BITS-1:0]          write_signature_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [SIG_BITS-1:0]          signature_out_o,
  output logic [OFFSET_BITS-1:0]       offset_out_o,
  output logic [pst_pkg::USED_W-1:0]   used_entries_o,
  output logic [pst_pkg::EVICT_W-1:0]  evictions_o
);
  import pst_pkg::*;

  localparam int unsigned AGE_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned RD_W   = 1 + SIG_BITS + OFFSET_BITS + AGE_W;
  localparam int unsigned LEVELS = ($clog2(ENTRIES) + 1) / 2;
  localparam int unsigned LVL_W  = $clog2(LEVELS + 1);
  localparam int unsigned DW     = (OFFSET_BITS > DELTA_BITS) ? OFFSET_BITS : DELTA_BITS;
  localparam int unsigned SW     = (SIG_BITS > DELTA_BITS) ? SIG_BITS : DELTA_BITS;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_TREE, S_COMMIT} state_e;

  state_e                  state_q;
  logic [LVL_W-1:0]        lvl_q;
  logic [MODE_W-1:0]       mode_q;
  logic [TAG_BITS-1:0]     tag_q;
  logic [OFFSET_BITS-1:0]  off_q;
  logic [SIG_BITS-1:0]     wsig_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        cnt_d;
  logic [EVICT_W-1:0]      evict_q;
  logic [EVICT_W-1:0]      evict_d;
  logic                    out_valid_q;
  logic                    hit_q;
  logic [SIG_BITS-1:0]     sig_out_q;
  logic [OFFSET_BITS-1:0]  off_out_q;

  pst_ctrl_t               ctrl;
  logic [RD_W-1:0]         leaf [ENTRIES];
  logic [RD_W-1:0]         root;
  logic                    r_hit;
  logic [SIG_BITS-1:0]     r_sig;
  logic [OFFSET_BITS-1:0]  r_off;
  logic [AGE_W-1:0]        r_age;
  logic [AGE_W-1:0]        touch_age;
  logic [DW-1:0]           diff;
  logic [SW-1:0]           sig_mix;
  logic [SIG_BITS-1:0]     new_sig;
  logic [SIG_BITS-1:0]     wr_sig;
  logic                    is_write;
  logic                    full;
  logic                    commit_go;
  logic                    alloc;

  assign r_hit = root[RD_W-1];
  assign r_sig = root[SIG_BITS+OFFSET_BITS+AGE_W-1 -: SIG_BITS];
  assign r_off = root[OFFSET_BITS+AGE_W-1 -: OFFSET_BITS];
  assign r_age = root[AGE_W-1:0];

  assign is_write  = (mode_q == MODE_UPDATE) || (mode_q == MODE_WRITE);
  assign full      = (cnt_q == CNT_W'(ENTRIES));
  assign commit_go = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);
  assign alloc     = commit_go && is_write && !r_hit;
  assign touch_age = r_hit ? r_age : AGE_W'(ENTRIES - 1);

  assign diff    = DW'(off_q) - DW'(r_off);
  assign sig_mix = (SW'(r_sig) << SIG_SHIFT) ^ SW'(diff[DELTA_BITS-1:0]);
  assign new_sig = sig_mix[SIG_BITS-1:0];
  assign wr_sig  = (mode_q == MODE_WRITE) ? wsig_q : new_sig;

  assign cnt_d   = (alloc && !full) ? cnt_q + CNT_W'(1) : cnt_q;
  assign evict_d = (alloc && full && (evict_q != '1)) ? evict_q + EVICT_W'(1) : evict_q;

  always_comb begin
    ctrl        = '0;
    ctrl.lookup = (state_q == S_LOOK);
    ctrl.commit = commit_go;
    ctrl.write  = is_write;
    ctrl.touch  = is_write || r_hit;
    ctrl.hit    = r_hit;
    ctrl.full   = full;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pst_cell #(
      .IDX        (i),
      .ENTRIES    (ENTRIES),
      .TAG_BITS   (TAG_BITS),
      .SIG_BITS   (SIG_BITS),
      .OFFSET_BITS(OFFSET_BITS),
      .AGE_W      (AGE_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .tag_i (tag_q),
      .sig_i (wr_sig),
      .off_i (off_q),
      .age_i (touch_age),
      .cnt_i (cnt_q),
      .rd_o  (leaf[i])
    );
  end

  pst_tree #(
    .N(ENTRIES),
    .W(RD_W)
  ) u_tree (
    .clk_i (clk_i),
    .leaf_i(leaf),
    .root_o(root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      mode_q      <= '0;
      tag_q       <= '0;
      off_q       <= '0;
      wsig_q      <= '0;
      cnt_q       <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      sig_out_q   <= '0;
      off_out_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            tag_q   <= page_tag_i;
            off_q   <= block_offset_i;
            wsig_q  <= write_signature_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          lvl_q   <= '0;
          state_q <= S_TREE;
        end
        S_TREE: begin
          lvl_q <= lvl_q + LVL_W'(1);
          if (lvl_q == LVL_W'(LEVELS - 1)) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_go) begin
            cnt_q       <= cnt_d;
            evict_q     <= evict_d;
            out_valid_q <= 1'b1;
            hit_q       <= r_hit;
            sig_out_q   <= is_write ? wr_sig : r_sig;
            off_out_q   <= is_write ? off_q : r_off;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign signature_out_o = sig_out_q;
  assign offset_out_o    = off_out_q;
  assign used_entries_o  = USED_W'(cnt_q);
  assign evictions_o     = evict_q;

endmodule
